@@ rtl/chunk_interval_root_estimator_defines.svh @@
// ---------------------------------------------------------------------------
// Chunk interval root estimator: assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CHUNK_INTERVAL_ROOT_ESTIMATOR_DEFINES_SVH
`define CHUNK_INTERVAL_ROOT_ESTIMATOR_DEFINES_SVH

// property that must hold at every edge out of reset
`define CIRE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CIRE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cire_pkg.sv @@
// ---------------------------------------------------------------------------
// Chunk interval root estimator package
// Widths, constants and the structs passed between sequencer and unit.
// ---------------------------------------------------------------------------
package cire_pkg;

   // field widths
   localparam int IVL_W       = 42;            // signed interval
   localparam int MAG_W       = 41;            // target, quotient, root
   localparam int EXTRA_W     = 6;
   localparam int PROD_W      = 48;            // known product
   localparam int CNT_W       = 6;
   localparam int TOT_W       = CNT_W + 1;
   localparam int MAX_DIMS    = 32;

   // stream and register port widths
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 48;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;

   // iteration counts of the shared unit
   localparam int STEPS       = MAG_W;
   localparam int STEP_CNT_W  = $clog2(STEPS);
   localparam int BIT_TOP     = MAG_W - 1;

   localparam logic [PROD_W-1:0] PRODUCT_MAX    = {PROD_W{1'b1}};
   localparam logic [MAG_W-1:0]  DEFAULT_TARGET = MAG_W'(1000000);

   localparam logic [CSR_ADDR_W-4:0] REG_TARGET = '0;

   // request opcodes
   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_FINISH = 1'b1
   } opcode_type;

   typedef enum logic {
      UOP_MUL = 1'b0,
      UOP_DIV = 1'b1
   } unit_op_type;

   // request to the shared multiply / divide unit
   typedef struct packed {
      logic                start;
      unit_op_type         op;
      logic [PROD_W-1:0]   a;     // multiplicand or divisor
      logic [MAG_W-1:0]    b;     // multiplier or dividend
      logic [PROD_W-1:0]   lim;   // product limit
   } unit_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic                over;  // product exceeded limit
      logic [PROD_W-1:0]   prod;
      logic [MAG_W-1:0]    quo;
   } unit_rsp_type;

   typedef struct packed {
      logic                opcode;
      logic [IVL_W-1:0]    interval;
      logic [EXTRA_W-1:0]  extra_unknown;
   } item_type;

   typedef struct packed {
      logic                valid;
      logic [MAG_W-1:0]    root;
      logic                mixed;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0]    known_count;
      logic [CNT_W-1:0]    unknown_count;
      logic                unit_busy;
   } seq_stat_type;

endpackage

@@ rtl/cire_unit.sv @@
// ---------------------------------------------------------------------------
// Shared multiply / divide unit
// One bit per cycle, MSB first: limited multiply with sticky overflow, or
// restoring divide.
// ---------------------------------------------------------------------------
module cire_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  cire_pkg::unit_req_type req,
   output cire_pkg::unit_rsp_type rsp
);
   import cire_pkg::*;

   localparam int MUL_W = PROD_W + 2;
   localparam int DIV_W = PROD_W + 1;
   localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(STEPS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  over_ff, over_in;
   unit_op_type           op_ff, op_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]     a_ff, a_in;
   logic [MAG_W-1:0]      b_ff, b_in;
   logic [PROD_W-1:0]     lim_ff, lim_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [MAG_W-1:0]      quo_ff, quo_in;

   logic [MUL_W-1:0]      t_mul;
   logic                  mul_over;
   logic [DIV_W-1:0]      t_div, d_div;
   logic                  div_ge;

   // one step of either operation
   always_comb begin
      t_mul    = {1'b0, acc_ff, 1'b0} + (b_ff[MAG_W-1] ? MUL_W'(a_ff) : '0);
      mul_over = t_mul > MUL_W'(lim_ff);
      t_div    = {acc_ff, b_ff[MAG_W-1]};
      div_ge   = t_div >= DIV_W'(a_ff);
      d_div    = t_div - DIV_W'(a_ff);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      over_in = over_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      lim_in  = lim_ff;
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      if (!busy_ff) begin
         if (req.start) begin
            busy_in = 1'b1;
            over_in = 1'b0;
            op_in   = req.op;
            cnt_in  = '0;
            a_in    = req.a;
            b_in    = req.b;
            lim_in  = req.lim;
            acc_in  = '0;
            quo_in  = '0;
         end
      end else begin
         b_in   = b_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (op_ff == UOP_MUL) begin
            if (!over_ff) begin
               if (mul_over) begin
                  over_in = 1'b1;
               end else begin
                  acc_in = t_mul[PROD_W-1:0];
               end
            end
         end else begin
            acc_in = div_ge ? d_div[PROD_W-1:0] : t_div[PROD_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], div_ge};
         end
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      over_ff <= over_in;
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      lim_ff  <= lim_in;
      acc_ff  <= acc_in;
      quo_ff  <= quo_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.over = over_ff;
   assign rsp.prod = acc_ff;
   assign rsp.quo  = quo_ff;

endmodule

@@ rtl/cire_seq.sv @@
// ---------------------------------------------------------------------------
// Estimator sequencer
// Holds the dimension state and drives the shared unit: product update on
// add items, target divide and bitwise root search on finish items.
// ---------------------------------------------------------------------------
module cire_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_valid,
   output logic                       item_ready,
   input  cire_pkg::item_type         item,
   input  logic [cire_pkg::MAG_W-1:0] target,
   input  logic                       out_free,
   output cire_pkg::result_type       res,
   output cire_pkg::unit_req_type     ureq,
   input  cire_pkg::unit_rsp_type     ursp,
   output cire_pkg::seq_stat_type     stat
);
   import cire_pkg::*;

   localparam int BIT_W = $clog2(MAG_W);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_PROD = 8'b0000_0010,
      ST_DIV  = 8'b0000_0100,
      ST_CAND = 8'b0000_1000,
      ST_POW  = 8'b0001_0000,
      ST_WPOW = 8'b0010_0000,
      ST_NEXT = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [PROD_W-1:0] kp_ff, kp_in;
   logic [CNT_W-1:0]  known_ff, known_in;
   logic [CNT_W-1:0]  unk_ff, unk_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  pow_ff, pow_in;
   logic              mixed_ff, mixed_in;
   logic [MAG_W-1:0]  q_ff, q_in;
   logic [MAG_W-1:0]  r_ff, r_in;
   logic [MAG_W-1:0]  acc_ff, acc_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;

   logic [MAG_W-1:0]  cand;
   logic [MAG_W-1:0]  tgt_eff;
   logic [TOT_W-1:0]  total;
   logic              dims_full;
   logic              positive;
   logic [CNT_W-1:0]  n_pick;

   always_comb begin
      cand      = r_ff | (MAG_W'(1) << bit_ff);
      tgt_eff   = (target == '0) ? DEFAULT_TARGET : target;
      total     = TOT_W'(known_ff) + TOT_W'(unk_ff);
      dims_full = total >= TOT_W'(MAX_DIMS);
      positive  = !item.interval[IVL_W-1] && (item.interval != '0);
      n_pick    = (unk_ff != '0) ? unk_ff : item.extra_unknown;
   end

   // next state and unit requests
   always_comb begin
      state_in = state_ff;
      kp_in    = kp_ff;
      known_in = known_ff;
      unk_in   = unk_ff;
      n_in     = n_ff;
      pow_in   = pow_ff;
      mixed_in = mixed_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      acc_in   = acc_ff;
      bit_in   = bit_ff;
      ureq     = '{start: 1'b0, op: UOP_MUL, a: kp_ff,
                   b: item.interval[MAG_W-1:0], lim: PRODUCT_MAX};
      res      = '{valid: 1'b0, root: r_ff, mixed: mixed_ff};
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (item.opcode == OP_ADD) begin
                  if (!dims_full) begin
                     if (positive) begin
                        ureq.start = 1'b1;
                        state_in   = ST_PROD;
                     end else begin
                        unk_in = unk_ff + 1'b1;
                     end
                  end
               end else begin
                  mixed_in = (item.extra_unknown != '0) && (unk_ff != '0);
                  n_in     = n_pick;
                  if (n_pick == '0) begin
                     r_in     = '0;
                     state_in = ST_FIN;
                  end else begin
                     ureq.start = 1'b1;
                     ureq.op    = UOP_DIV;
                     ureq.b     = tgt_eff;
                     state_in   = ST_DIV;
                  end
               end
            end
         end
         ST_PROD: begin
            if (ursp.done) begin
               kp_in    = ursp.over ? PRODUCT_MAX : ursp.prod;
               known_in = known_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (ursp.done) begin
               q_in     = (ursp.quo == '0) ? MAG_W'(1) : ursp.quo;
               r_in     = '0;
               bit_in   = BIT_W'(BIT_TOP);
               state_in = ST_CAND;
            end
         end
         ST_CAND: begin
            if (cand > q_ff) begin
               state_in = ST_NEXT;
            end else begin
               acc_in   = MAG_W'(1);
               pow_in   = '0;
               state_in = ST_POW;
            end
         end
         ST_POW: begin
            ureq.start = 1'b1;
            ureq.a     = PROD_W'(acc_ff);
            ureq.b     = cand;
            ureq.lim   = PROD_W'(q_ff);
            state_in   = ST_WPOW;
         end
         ST_WPOW: begin
            if (ursp.done) begin
               if (ursp.over) begin
                  state_in = ST_NEXT;
               end else if (pow_ff + 1'b1 == n_ff) begin
                  r_in     = cand;
                  state_in = ST_NEXT;
               end else begin
                  acc_in   = ursp.prod[MAG_W-1:0];
                  pow_in   = pow_ff + 1'b1;
                  state_in = ST_POW;
               end
            end
         end
         ST_NEXT: begin
            if (bit_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = ST_CAND;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               res.valid = 1'b1;
               kp_in     = PROD_W'(1);
               known_in  = '0;
               unk_in    = '0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and dimension state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kp_ff    <= PROD_W'(1);
         known_ff <= '0;
         unk_ff   <= '0;
      end else begin
         state_ff <= state_in;
         kp_ff    <= kp_in;
         known_ff <= known_in;
         unk_ff   <= unk_in;
      end
   end

   // root search working registers
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      pow_ff   <= pow_in;
      mixed_ff <= mixed_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      acc_ff   <= acc_in;
      bit_ff   <= bit_in;
   end

   assign item_ready         = (state_ff == ST_IDLE);
   assign stat.known_count   = known_ff;
   assign stat.unknown_count = unk_ff;
   assign stat.unit_busy     = ursp.busy;

endmodule

@@ rtl/chunk_interval_root_estimator.sv @@
// ---------------------------------------------------------------------------
// Chunk interval root estimator
// Collects dimension intervals and returns the integer n-th root of
// max(1, target / known product) on a finish item, or 0 when n is zero.
// ---------------------------------------------------------------------------
// Flow: every item is taken in the idle state. An add item with a zero or
// negative interval, or one beyond 32 dimensions, needs no unit operation;
// one with a positive interval waits on the 41-step shared multiply unit.
// A finish item with a root order n of zero goes straight to the result
// hand-off; otherwise it runs the 41-step divide, then for each of the 41
// root bits a candidate check and up to n trial multiplies (fewer once the
// power passes the quotient), then hands the result on once the output
// register is free. The result register frees the sequencer, so add items
// are taken while a result waits on rsp_tready.
`include "chunk_interval_root_estimator_defines.svh"

module chunk_interval_root_estimator (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cire_pkg::REQ_DATA_W-1:0] req_tdata,   // interval[41:0], extra_unknown[47:42]
   input  logic                            req_tuser,   // opcode
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cire_pkg::RSP_DATA_W-1:0] rsp_tdata,   // chunk_interval[40:0], zero[47:41]
   output logic                            rsp_tuser,   // mixed_mode_error
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cire_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cire_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cire_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import cire_pkg::*;

   logic [MAG_W-1:0] target_ff, target_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0] rsp_root_ff, rsp_root_in;
   logic             rsp_err_ff, rsp_err_in;

   item_type         item;
   result_type       res;
   unit_req_type     ureq;
   unit_rsp_type     ursp;
   seq_stat_type     stat;
   logic             csr_wr;
   logic             csr_hit;

   // register port
   always_comb begin
      csr_wr    = csr_psel && csr_penable && csr_pwrite;
      csr_hit   = csr_paddr[CSR_ADDR_W-1:3] == REG_TARGET;
      target_in = target_ff;
      if (csr_wr && csr_hit) begin
         target_in = csr_pwdata[MAG_W-1:0];
      end
      csr_prdata = csr_hit ? CSR_DATA_W'(target_ff) : '0;
   end
   assign csr_pready = 1'b1;

   // unpack request
   always_comb begin
      item.opcode        = req_tuser;
      item.interval      = req_tdata[IVL_W-1:0];
      item.extra_unknown = req_tdata[IVL_W+EXTRA_W-1:IVL_W];
   end

   cire_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .target     (target_ff),
      .out_free   (!rsp_valid_ff),
      .res        (res),
      .ureq       (ureq),
      .ursp       (ursp),
      .stat       (stat)
   );

   cire_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (ureq),
      .rsp   (ursp)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_root_in  = rsp_root_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_root_in  = res.root;
         rsp_err_in   = res.mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= DEFAULT_TARGET;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_root_ff <= rsp_root_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_root_ff);
   assign rsp_tuser  = rsp_err_ff;

   // checks
   `CIRE_ASSERT(a_no_take_busy, !(req_tvalid && req_tready && stat.unit_busy),
      "item taken while unit busy")
   `CIRE_ASSERT(a_dims_bound,
      (TOT_W'(stat.known_count) + TOT_W'(stat.unknown_count)) <= TOT_W'(MAX_DIMS),
      "dimension count past limit")
   `CIRE_ASSERT(a_slot_free, !(res.valid && rsp_valid_ff),
      "result overwrote pending transfer")
   `CIRE_ASSERT_NXT(a_clear_after, res.valid,
      (stat.known_count == '0) && (stat.unknown_count == '0),
      "state not cleared after finish")

endmodule

@@ bench/chunk_interval_root_estimator_tb.sv @@
// ---------------------------------------------------------------------------
// Chunk interval root estimator testbench
// Streams dimension and finish items into the block, predicts each estimate
// with an in-bench integer root search, and checks every result transfer
// against the oldest expected estimate. Covers a directed set of corner cases,
// then random dimension sets with some noise items under several target
// settings, with random back-pressure, a long output hold-off and a full pause.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chunk_interval_root_estimator_tb;
   import cire_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_TARGET   = {REG_TARGET, 3'b000};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = 4'h8;

   localparam int     SETTLE_CYCLES = 50;     // covers a positive add
   localparam int     HOLD_CYCLES   = 3000;
   localparam int     PHASE_ITEMS   = 240;
   localparam int     SETTINGS      = 8;
   localparam longint ITEM_BUDGET   = 400;

   typedef struct packed {
      logic [MAG_W-1:0] root;
      logic             mixed;
   } estimate_type;

   typedef struct packed {
      opcode_type         op;
      logic [IVL_W-1:0]   ivl;
      logic [EXTRA_W-1:0] extra;
      logic [6:0]         rep;
      logic               typed;
      logic [MAG_W-1:0]   root;
      logic               mixed;
   } stim_row_type;

   // corner cases at the reset target of 1000000
   localparam int DIRECTED_ROWS = 26;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // nothing added: no unknowns, estimate 0
      '{OP_FINISH, IVL_W'(0),          6'd0,  7'd1,  1'b1, MAG_W'(0),       1'b0},
      '{OP_FINISH, {IVL_W{1'b1}},      6'd0,  7'd1,  1'b1, MAG_W'(0),       1'b0},
      // added unknown plus explicit count: mixed mode, still uses added count
      '{OP_ADD,    -IVL_W'(5),         6'h3F, 7'd1,  1'b0, MAG_W'(0),       1'b0},
      '{OP_FINISH, IVL_W'(0),          6'd3,  7'd1,  1'b1, MAG_W'(1000000), 1'b1},
      // explicit count alone
      '{OP_FINISH, IVL_W'(0),          6'd1,  7'd1,  1'b1, MAG_W'(1000000), 1'b0},
      // zero interval is unknown
      '{OP_ADD,    IVL_W'(0),          6'd0,  7'd1,  1'b0, MAG_W'(0),       1'b0},
      '{OP_ADD,    IVL_W'(1000),       6'd0,  7'd1,  1'b0, MAG_W'(0),       1'b0},
      '{OP_FINISH, IVL_W'(0),          6'd0,  7'd1,  1'b1, MAG_W'(1000),    1'b0},
      // product saturates, quotient clamps to 1
      '{OP_ADD,    42'h100_0000_0000,  6'd0,  7'd2,  1'b0, MAG_W'(0),       1'b0},
      '{OP_ADD,    42'h300_0000_0000,  6'd0,  7'd1,  1'b0, MAG_W'(0),       1'b0},
      '{OP_FINISH, IVL_W'(0),          6'd0,  7'd1,  1'b1, MAG_W'(1),       1'b0},
      // square root
      '{OP_ADD,    {IVL_W{1'b1}},      6'd0,  7'd2,  1'b0, MAG_W'(0),       1'b0},
      '{OP_FINISH, IVL_W'(0),          6'd0,  7'd1,  1'b1, MAG_W'(1000),    1'b0},
      // largest explicit counts
      '{OP_FINISH, IVL_W'(0),          6'd32, 7'd1,  1'b1, MAG_W'(1),       1'b0},
      '{OP_FINISH, IVL_W'(0),          6'd63, 7'd1,  1'b1, MAG_W'(1),       1'b0},
      // dimension list full: the extra unknown is dropped, so n stays 0
      '{OP_ADD,    IVL_W'(1),          6'd0,  7'd32, 1'b0, MAG_W'(0),       1'b0},
      '{OP_ADD,    {IVL_W{1'b1}},      6'd0,  7'd1,  1'b0, MAG_W'(0),       1'b0},
      '{OP_FINISH, IVL_W'(0),          6'd0,  7'd1,  1'b1, MAG_W'(0),       1'b0},
      // extreme bit patterns of the interval field
      '{OP_ADD,    42'h1FF_FFFF_FFFF,  6'd0,  7'd1,  1'b0, MAG_W'(0),       1'b0},
      '{OP_ADD,    42'h200_0000_0000,  6'd0,  7'd1,  1'b0, MAG_W'(0),       1'b0},
      '{OP_FINISH, IVL_W'(0),          6'd0,  7'd1,  1'b0, MAG_W'(0),       1'b0},
      // cube root of 333333
      '{OP_ADD,    IVL_W'(3),          6'd0,  7'd1,  1'b0, MAG_W'(0),       1'b0},
      '{OP_ADD,    -IVL_W'(7),         6'd0,  7'd3,  1'b0, MAG_W'(0),       1'b0},
      '{OP_FINISH, IVL_W'(0),          6'd0,  7'd1,  1'b0, MAG_W'(0),       1'b0},
      // explicit count with a known product
      '{OP_ADD,    IVL_W'(100),        6'd0,  7'd2,  1'b0, MAG_W'(0),       1'b0},
      '{OP_FINISH, IVL_W'(0),          6'd2,  7'd1,  1'b1, MAG_W'(10),      1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // interval[41:0], extra_unknown[47:42]
   logic                  req_tuser;   // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // chunk_interval[40:0], zero[47:41]
   logic                  rsp_tuser;   // mixed_mode_error
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [MAG_W-1:0]  target_now;
   logic [PROD_W-1:0] dims_product;
   int                dims_known;
   int                dims_unknown;
   estimate_type      pending_estimates[$];

   int     errors        = 0;
   int     items_sent    = 0;
   int     finishes_sent = 0;
   int     mixed_sent    = 0;
   int     results_seen  = 0;
   int     settings_run  = 0;
   longint cycle_count   = 0;
   longint cycle_budget  = 200000;
   int     rsp_hold_cycles = 0;
   bit     tx_steady = 1'b0;
   bit     rx_steady = 1'b0;

   chunk_interval_root_estimator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // mostly short gaps, the odd long one
   function automatic int idle_len();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 55) return 0;
      if (r < 90) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   // floor of the n-th root of q, one bit at a time from the top
   function automatic logic [MAG_W-1:0] nth_root(logic [MAG_W-1:0] q, int n);
      logic [MAG_W-1:0] r;
      logic [MAG_W-1:0] cand;
      logic [127:0]     acc;
      bit               fits;
      int               b;
      int               i;
      r = '0;
      for (b = MAG_W - 1; b >= 0; b--) begin
         cand = r | (MAG_W'(1) << b);
         fits = (cand <= q);
         acc  = 128'd1;
         for (i = 0; i < n && fits; i++) begin
            acc = acc * 128'(cand);
            if (acc > 128'(q)) fits = 1'b0;
         end
         if (fits) r = cand;
      end
      return r;
   endfunction

   // fold one accepted item into the dimension state; finish yields an estimate
   task automatic estimate_step(input opcode_type op, input logic [IVL_W-1:0] ivl,
                                input logic [EXTRA_W-1:0] extra,
                                output bit produced, output estimate_type est,
                                output int n_used);
      logic [63:0] tgt;
      logic [63:0] q;
      int          n;
      produced = 1'b0;
      est      = '0;
      n_used   = 0;
      if (op == OP_ADD) begin
         // a full dimension list drops further items
         if (dims_known + dims_unknown < MAX_DIMS) begin
            if (!ivl[IVL_W-1] && ivl != '0) begin
               if (64'(ivl) > 64'(PRODUCT_MAX) / 64'(dims_product))
                  dims_product = PRODUCT_MAX;
               else
                  dims_product = PROD_W'(64'(ivl) * 64'(dims_product));
               dims_known++;
            end else begin
               dims_unknown++;
            end
         end
      end else begin
         n = (dims_unknown != 0) ? dims_unknown : int'(extra);
         est.mixed = (extra != '0) && (dims_unknown != 0);
         if (n != 0) begin
            // zero target falls back to the default
            tgt = (target_now != '0) ? 64'(target_now) : 64'(DEFAULT_TARGET);
            q   = tgt / 64'(dims_product);
            if (q == 64'd0) q = 64'd1;
            est.root = nth_root(MAG_W'(q), n);
         end
         produced     = 1'b1;
         n_used       = n;
         dims_product = PROD_W'(1);
         dims_known   = 0;
         dims_unknown = 0;
      end
   endtask

   // offer one item after a random gap (none when steady), hold it until the transfer
   task automatic send_item(input opcode_type op, input logic [IVL_W-1:0] ivl,
                            input logic [EXTRA_W-1:0] extra, input bit typed,
                            input estimate_type typed_est);
      int           gap;
      bit           produced;
      estimate_type est;
      int           n;
      gap = tx_steady ? 0 : idle_len();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {extra, ivl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      estimate_step(op, ivl, extra, produced, est, n);
      items_sent++;
      cycle_budget += ITEM_BUDGET;
      if (produced) begin
         // worst case divide plus every root bit trying n multiplies
         cycle_budget += longint'(4) * longint'(45 + 41 * (2 + 43 * n));
         pending_estimates.push_back(typed ? typed_est : est);
         finishes_sent++;
         if (est.mixed) mixed_sent++;
      end
   endtask

   // stop offering and wait for every outstanding estimate, then let adds settle
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_TARGET) target_now = data[MAG_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_target_readback();
      logic [CSR_DATA_W-1:0] got;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_TARGET;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== CSR_DATA_W'(target_now)) begin
         $display("%0t: target readback: expected %0d, got %0d", $time, target_now, got);
         errors++;
      end
   endtask

   function automatic logic [IVL_W-1:0] pick_interval();
      int s;
      s = int'($urandom_range(0, 99));
      if (s < 35) return IVL_W'($urandom_range(1, 64));
      if (s < 50) return IVL_W'($urandom_range(1, 1 << 20));
      if (s < 65) return {1'b0, MAG_W'({$urandom, $urandom})};
      if (s < 75) return '0;
      if (s < 85) return -IVL_W'($urandom_range(1, 64));
      return {1'b1, MAG_W'({$urandom, $urandom})};
   endfunction

   // small explicit counts mostly; large ones are slow, so kept rare
   function automatic logic [EXTRA_W-1:0] pick_extra();
      int s;
      s = int'($urandom_range(0, 99));
      if (s < 60) return '0;
      if (s < 85) return EXTRA_W'($urandom_range(1, 4));
      if (s < 97) return EXTRA_W'($urandom_range(5, MAX_DIMS));
      return EXTRA_W'($urandom_range(MAX_DIMS + 1, 63));
   endfunction

   // dimension sets with random content, a little noise in between
   task automatic run_random_phase(input int quota, input bit with_hold,
                                   input bit with_pause);
      int           start_count;
      int           k;
      int           d;
      bit           paused;
      estimate_type none;
      none        = '0;
      paused      = 1'b0;
      start_count = items_sent;
      if (with_hold) begin
         // output held off while cheap finishes keep coming: input must stall
         rsp_hold_cycles = HOLD_CYCLES;
         cycle_budget   += longint'(4 * HOLD_CYCLES);
         tx_steady       = 1'b1;
         for (d = 0; d < 24; d++)
            send_item(OP_FINISH, IVL_W'({$urandom, $urandom}), '0, 1'b0, none);
         tx_steady = 1'b0;
      end
      while (items_sent - start_count < quota) begin
         if (with_pause && !paused && items_sent - start_count >= quota / 2) begin
            drain_results();
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 5) begin
            send_item(opcode_type'($urandom_range(0, 1)), IVL_W'({$urandom, $urandom}),
                      EXTRA_W'($urandom), 1'b0, none);
         end else begin
            k = ($urandom_range(0, 99) < 3) ? int'($urandom_range(28, 36))
                                            : int'($urandom_range(0, 6));
            for (d = 0; d < k; d++)
               send_item(OP_ADD, pick_interval(), EXTRA_W'($urandom), 1'b0, none);
            send_item(OP_FINISH, IVL_W'({$urandom, $urandom}), pick_extra(), 1'b0, none);
         end
      end
   endtask

   // result side ready: random stalls, steady stretches, one long hold-off
   initial begin : rsp_side
      int wait_left;
      wait_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end else if (wait_left > 0) begin
            rsp_tready <= 1'b0;
            wait_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 2) == 0) wait_left = idle_len();
         end
      end
   end

   // compare each result transfer with the oldest estimate
   always @(posedge clock) begin : rsp_check
      estimate_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_estimates.size() == 0) begin
            $display("%0t: unexpected result: interval %0d mixed %0b",
                     $time, rsp_tdata[MAG_W-1:0], rsp_tuser);
            errors++;
         end else begin
            want = pending_estimates.pop_front();
            results_seen++;
            if (rsp_tdata[MAG_W-1:0] !== want.root || rsp_tuser !== want.mixed ||
                rsp_tdata[RSP_DATA_W-1:MAG_W] !== '0) begin
               $display("%0t: expected interval %0d mixed %0b, got interval %0d mixed %0b pad %h",
                        $time, want.root, want.mixed, rsp_tdata[MAG_W-1:0], rsp_tuser,
                        rsp_tdata[RSP_DATA_W-1:MAG_W]);
               errors++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count <= cycle_budget) @(posedge clock);
      $display("%0t: timed out with %0d estimates outstanding", $time,
               pending_estimates.size());
      $display("chunk_interval_root_estimator regression: fail");
      $finish;
   end

   initial begin : stimulus
      int                    p;
      int                    i;
      int                    j;
      logic [CSR_DATA_W-1:0] setting;
      estimate_type          typed_est;
      stim_row_type          row;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      target_now   = DEFAULT_TARGET;
      dims_product = PROD_W'(1);
      dims_known   = 0;
      dims_unknown = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_target_readback();

      // directed corner cases
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         row       = DIRECTED[i];
         typed_est = '{root: row.root, mixed: row.mixed};
         for (j = 0; j < int'(row.rep); j++)
            send_item(row.op, row.ivl, row.extra, row.typed, typed_est);
      end
      drain_results();

      // random sets under each target setting
      for (p = 0; p < SETTINGS; p++) begin
         case (p)
            0:       setting = '0;
            1:       setting = 64'd1;
            2:       setting = 64'h0000_0100_0000_0000;
            3:       setting = {$urandom, $urandom} | 64'h0000_01FF_FFFF_FFFF;
            4:       setting = 64'($urandom_range(2, 1 << 20));
            5:       setting = {$urandom, $urandom};
            6:       setting = 64'($urandom_range(1000, 1 << 30));
            default: setting = 64'(DEFAULT_TARGET);
         endcase
         csr_write(ADDR_TARGET, setting);
         // unmapped register: must leave the target alone
         if (p == 1) csr_write(ADDR_UNMAPPED, {$urandom, $urandom});
         check_target_readback();
         settings_run++;
         if (p == 5) begin
            tx_steady = 1'b1;
            rx_steady = 1'b1;
         end
         run_random_phase(PHASE_ITEMS, p == 2, p == 4);
         tx_steady = 1'b0;
         rx_steady = 1'b0;
         drain_results();
      end

      $display("Sent %0d items (%0d finish, %0d mixed-mode) over %0d target settings.",
               items_sent, finishes_sent, mixed_sent, settings_run);
      $display("Checked %0d estimates, %0d mismatches.", results_seen, errors);
      if (errors == 0)
         $display("chunk_interval_root_estimator regression: pass");
      else
         $display("chunk_interval_root_estimator regression: fail");
      $finish;
   end

endmodule
